// File: rtl/fflk_pkg.sv
package fflk_pkg;

    // Defaults
    localparam int DIST_FRAC_BITS_DEF = 4;

    // Field and datapath widths
    localparam int DIST_W  = 12;
    localparam int CLAMP_W = 10;
    localparam int MU_W    = 13;
    localparam int FILL_W  = 15;
    localparam int THR_W   = 7;
    localparam int NUM_W   = 22;
    localparam int DEN_W   = 16;
    localparam int RCP_W   = 17;

    typedef logic [CLAMP_W-1:0] dist_t;
    typedef logic [MU_W-1:0]    mu_t;
    typedef logic [FILL_W-1:0]  fill_t;
    typedef logic [1:0]         kind_t;
    typedef logic [1:0]         pct_t;

    // Register reset values and indexes
    localparam logic [THR_W-1:0]   THR_RESET  = 7'd75;
    localparam logic [CLAMP_W-1:0] MAXD_RESET = 10'd688;
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_MAX_DIST  = 1'b1;

    localparam mu_t   MU_ONE   = 13'd4096;
    localparam fill_t FILL_MAX = 15'd25600;

    // Reciprocals: floor(v/d) == (v*m) >> k for any 16-bit v
    localparam logic [RCP_W-1:0] RECIP_7  = 17'd74899;  // k = 19
    localparam logic [RCP_W-1:0] RECIP_13 = 17'd80660;  // k = 20
    localparam logic [RCP_W-1:0] RECIP_12 = 17'd87382;  // k = 20

    // Membership kinds
    localparam kind_t KIND_NEAR = 2'd0;
    localparam kind_t KIND_MED  = 2'd1;
    localparam kind_t KIND_FAR  = 2'd2;

    // Rule consequents
    localparam pct_t PCT_ZERO = 2'd0;
    localparam pct_t PCT_HALF = 2'd1;
    localparam pct_t PCT_FULL = 2'd2;

    // Negative distances go to zero, large ones to the limit
    function automatic dist_t clamp_dist(input logic [DIST_W-1:0] raw, input dist_t lim);
        dist_t res;
        if (raw[DIST_W-1])
            res = '0;
        else if (raw[DIST_W-2:0] > {1'b0, lim})
            res = lim;
        else
            res = raw[CLAMP_W-1:0];
        return res;
    endfunction

    // Rule r: front row r/3 (far, medium, near), back column r%3 (far, medium, near)
    function automatic kind_t rule_front(input logic [3:0] r);
        kind_t k;
        case (r)
            4'd0, 4'd1, 4'd2: k = KIND_FAR;
            4'd3, 4'd4, 4'd5: k = KIND_MED;
            default:          k = KIND_NEAR;
        endcase
        return k;
    endfunction

    function automatic kind_t rule_back(input logic [3:0] r);
        kind_t k;
        case (r)
            4'd0, 4'd3, 4'd6: k = KIND_FAR;
            4'd1, 4'd4, 4'd7: k = KIND_MED;
            default:          k = KIND_NEAR;
        endcase
        return k;
    endfunction

    function automatic pct_t rule_pct(input logic [3:0] r);
        pct_t p;
        case (r)
            4'd0:             p = PCT_ZERO;
            4'd1, 4'd3, 4'd4: p = PCT_HALF;
            default:          p = PCT_FULL;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/fuzzy_fill_level_lock_unit.sv
// Channel  | Dir | Signals                          | Contents (lowest bit first)
// ---------+-----+----------------------------------+-------------------------------------
// input    | in  | s_tvalid, s_tready, s_tdata[71:0] | plastic_front, plastic_back,
//          |     |                                  | paper_front, paper_back, metal_front,
//          |     |                                  | metal_back (12 bits signed each)
// result   | out | m_tvalid, m_tready, m_tdata[47:0] | plastic_fill, paper_fill, metal_fill
//          |     | m_tuser[2:0]                     | locked, lock_entered, lock_released
// config   | in  | psel, penable, pwrite, paddr,    | 0x0 lock_threshold, 0x4 max_distance
//          |     | pwdata, prdata, pready           |
//
// Each item passes, per bin, through 6 membership steps on the shared reciprocal
// multiplier, 9 rule-accumulate steps, 1 divide setup and 15 steps of the serial
// restoring divider (skipped on a zero weight sum), between the idle and done states.
// s_tready is high only while the sequencer is idle.
// The result register holds a finished item while the next one is taken; the
// sequencer waits in its final state only if that register is still full.
// rst_n resets sequencer, lock flag, output valid and config registers; datapath not.
module fuzzy_fill_level_lock_unit #(
    parameter int DIST_FRAC_BITS = fflk_pkg::DIST_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // plastic_front, plastic_back, paper_front,
                                   // paper_back, metal_front, metal_back
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // plastic_fill, paper_fill, metal_fill, 3'b0
    output logic [2:0]  m_tuser,   // locked, lock_entered, lock_released
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Membership breakpoints in distance units
    localparam logic [15:0] X8  = 16'(8  << DIST_FRAC_BITS);
    localparam logic [15:0] X10 = 16'(10 << DIST_FRAC_BITS);
    localparam logic [15:0] X15 = 16'(15 << DIST_FRAC_BITS);
    localparam logic [15:0] X23 = 16'(23 << DIST_FRAC_BITS);
    localparam logic [15:0] X25 = 16'(25 << DIST_FRAC_BITS);
    localparam logic [15:0] X35 = 16'(35 << DIST_FRAC_BITS);
    localparam logic [15:0] X38 = 16'(38 << DIST_FRAC_BITS);
    localparam int SHL = 12 - DIST_FRAC_BITS;

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MEMB = 3'd1;
    localparam logic [2:0] ST_RULE = 3'd2;
    localparam logic [2:0] ST_DSET = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    // Control registers
    logic [2:0] state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] bin_reg, bin_next;
    logic       out_valid_reg, out_valid_next;
    logic       lock_reg, lock_next;
    logic [fflk_pkg::THR_W-1:0] thr_reg, thr_next;
    fflk_pkg::dist_t            maxd_reg, maxd_next;

    // Payload registers
    fflk_pkg::dist_t dist_reg [6];
    fflk_pkg::dist_t dist_next [6];
    fflk_pkg::mu_t   mu_front_reg [3];
    fflk_pkg::mu_t   mu_front_next [3];
    fflk_pkg::mu_t   mu_back_reg [3];
    fflk_pkg::mu_t   mu_back_next [3];
    fflk_pkg::fill_t fill_reg [3];
    fflk_pkg::fill_t fill_next [3];
    logic [fflk_pkg::NUM_W-1:0] num_reg, num_next;
    logic [fflk_pkg::DEN_W-1:0] den_reg, den_next;
    logic [fflk_pkg::DEN_W:0]   rem_reg, rem_next;
    logic [14:0]                dvd_reg, dvd_next;
    fflk_pkg::fill_t            quo_reg, quo_next;
    fflk_pkg::fill_t            out_fill_reg [3];
    fflk_pkg::fill_t            out_fill_next [3];
    logic [2:0]                 out_flags_reg, out_flags_next;

    // APB port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == fflk_pkg::REG_MAX_DIST) ?
                    {22'd0, maxd_reg} : {25'd0, thr_reg};

    always_comb
    begin
        thr_next  = thr_reg;
        maxd_next = maxd_reg;
        if (cfg_wr)
        begin
            if (paddr[2] == fflk_pkg::REG_THRESHOLD)
                thr_next = pwdata[fflk_pkg::THR_W-1:0];
            else
                maxd_next = pwdata[fflk_pkg::CLAMP_W-1:0];
        end
    end

    // Membership step: select distance and kind
    logic                 side;
    fflk_pkg::kind_t      kind;
    logic [2:0]           dsel;
    logic [15:0]          mx;
    logic                 mu_sat;
    fflk_pkg::mu_t        mu_const;
    logic [15:0]          dlt;
    logic [fflk_pkg::RCP_W-1:0] recip;
    logic                 by7;
    logic [15:0]          vval;
    logic [32:0]          prod;
    fflk_pkg::mu_t        mu_calc;

    assign side = (step_reg >= 4'd3);
    assign kind = side ? 2'(step_reg - 4'd3) : step_reg[1:0];
    assign dsel = {bin_reg, side};
    assign mx   = {6'd0, dist_reg[dsel]};

    always_comb
    begin
        mu_sat   = 1'b1;
        mu_const = '0;
        dlt      = '0;
        recip    = '0;
        by7      = 1'b0;
        case (kind)
            fflk_pkg::KIND_NEAR:
            begin
                if (mx <= X8)
                    mu_const = fflk_pkg::MU_ONE;
                else if (mx < X15)
                begin
                    mu_sat = 1'b0;
                    dlt    = X15 - mx;
                    recip  = fflk_pkg::RECIP_7;
                    by7    = 1'b1;
                end
            end
            fflk_pkg::KIND_MED:
            begin
                if (mx > X10 && mx <= X23)
                begin
                    mu_sat = 1'b0;
                    dlt    = mx - X10;
                    recip  = fflk_pkg::RECIP_13;
                end
                else if (mx > X23 && mx < X35)
                begin
                    mu_sat = 1'b0;
                    dlt    = X35 - mx;
                    recip  = fflk_pkg::RECIP_12;
                end
            end
            fflk_pkg::KIND_FAR:
            begin
                if (mx >= X38)
                    mu_const = fflk_pkg::MU_ONE;
                else if (mx > X25)
                begin
                    mu_sat = 1'b0;
                    dlt    = mx - X25;
                    recip  = fflk_pkg::RECIP_13;
                end
            end
            default:
            begin
                mu_const = '0;
            end
        endcase
    end

    // Shared multiplier: scaled offset times reciprocal of the slope span
    assign vval = 16'(dlt << SHL);
    assign prod = 33'(vval) * 33'(recip);
    assign mu_calc = mu_sat ? mu_const : (by7 ? prod[31:19] : prod[32:20]);

    // Rule step: weight is the smaller membership, weighted by 0, 50 or 100
    fflk_pkg::mu_t              w_f, w_b, w_min;
    fflk_pkg::pct_t             pct;
    logic [fflk_pkg::NUM_W-1:0] w50, wc;

    assign w_f   = mu_front_reg[fflk_pkg::rule_front(step_reg)];
    assign w_b   = mu_back_reg[fflk_pkg::rule_back(step_reg)];
    assign w_min = (w_f < w_b) ? w_f : w_b;
    assign pct   = fflk_pkg::rule_pct(step_reg);
    assign w50   = (22'(w_min) << 5) + (22'(w_min) << 4) + (22'(w_min) << 1);

    always_comb
    begin
        case (pct)
            fflk_pkg::PCT_HALF: wc = w50;
            fflk_pkg::PCT_FULL: wc = w50 << 1;
            default:            wc = '0;
        endcase
    end

    // Divider step: shift in one dividend bit, subtract if it fits
    logic [fflk_pkg::DEN_W:0] trial;
    logic                     fits;

    assign trial = {rem_reg[fflk_pkg::DEN_W-1:0], dvd_reg[14]};
    assign fits  = (trial >= {1'b0, den_reg});

    // Lock decision on the finished fills
    logic [fflk_pkg::FILL_W-1:0] thr_fill;
    logic                        any_hit;
    logic                        out_free;

    assign thr_fill = {thr_reg, 8'd0};
    assign any_hit  = (fill_reg[0] >= thr_fill) || (fill_reg[1] >= thr_fill) ||
                      (fill_reg[2] >= thr_fill);
    assign out_free = !out_valid_reg || m_tready;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        bin_next       = bin_reg;
        out_valid_next = out_valid_reg;
        lock_next      = lock_reg;
        dist_next      = dist_reg;
        mu_front_next  = mu_front_reg;
        mu_back_next   = mu_back_reg;
        fill_next      = fill_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        out_fill_next  = out_fill_reg;
        out_flags_next = out_flags_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    for (int i = 0; i < 6; i++)
                        dist_next[i] = fflk_pkg::clamp_dist(s_tdata[12*i +: 12], maxd_reg);
                    bin_next   = '0;
                    step_next  = '0;
                    state_next = ST_MEMB;
                end
            end
            ST_MEMB:
            begin
                if (side)
                    mu_back_next[kind] = mu_calc;
                else
                    mu_front_next[kind] = mu_calc;
                if (step_reg == 4'd5)
                begin
                    step_next  = '0;
                    num_next   = '0;
                    den_next   = '0;
                    state_next = ST_RULE;
                end
                else
                    step_next = step_reg + 4'd1;
            end
            ST_RULE:
            begin
                num_next = num_reg + wc;
                den_next = den_reg + 16'(w_min);
                if (step_reg == 4'd8)
                begin
                    step_next  = '0;
                    state_next = ST_DSET;
                end
                else
                    step_next = step_reg + 4'd1;
            end
            ST_DSET:
            begin
                // dividend is num * 256; its top 15 bits are below den
                rem_next = 17'(num_reg[21:7]);
                dvd_next = {num_reg[6:0], 8'd0};
                quo_next = '0;
                step_next = '0;
                if (den_reg == '0)
                begin
                    fill_next[bin_reg] = '0;
                    if (bin_reg == 2'd2)
                        state_next = ST_DONE;
                    else
                    begin
                        bin_next   = bin_reg + 2'd1;
                        state_next = ST_MEMB;
                    end
                end
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = fits ? (trial - {1'b0, den_reg}) : trial;
                dvd_next = {dvd_reg[13:0], 1'b0};
                quo_next = {quo_reg[13:0], fits};
                if (step_reg == 4'd14)
                begin
                    fill_next[bin_reg] = {quo_reg[13:0], fits};
                    step_next          = '0;
                    if (bin_reg == 2'd2)
                        state_next = ST_DONE;
                    else
                    begin
                        bin_next   = bin_reg + 2'd1;
                        state_next = ST_MEMB;
                    end
                end
                else
                    step_next = step_reg + 4'd1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_fill_next  = fill_reg;
                    out_flags_next = {lock_reg & ~any_hit, any_hit & ~lock_reg, any_hit};
                    lock_next      = any_hit;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            bin_reg       <= '0;
            out_valid_reg <= 1'b0;
            lock_reg      <= 1'b0;
            thr_reg       <= fflk_pkg::THR_RESET;
            maxd_reg      <= fflk_pkg::MAXD_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            bin_reg       <= bin_next;
            out_valid_reg <= out_valid_next;
            lock_reg      <= lock_next;
            thr_reg       <= thr_next;
            maxd_reg      <= maxd_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        dist_reg      <= dist_next;
        mu_front_reg  <= mu_front_next;
        mu_back_reg   <= mu_back_next;
        fill_reg      <= fill_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        quo_reg       <= quo_next;
        out_fill_reg  <= out_fill_next;
        out_flags_reg <= out_flags_next;
    end

    // Ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_fill_reg[2], out_fill_reg[1], out_fill_reg[0]};
    assign m_tuser  = out_flags_reg;

    // Checks
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (den_reg != '0))
        else $error("divider running with zero weight sum");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready right after an accepted item");

    a_lock_matches: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (lock_reg == m_tuser[0]))
        else $error("lock flag differs from presented result");

    a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[1] && m_tuser[2]))
        else $error("lock entry and release on one item");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_fill_reg[0] <= fflk_pkg::FILL_MAX &&
                      out_fill_reg[1] <= fflk_pkg::FILL_MAX &&
                      out_fill_reg[2] <= fflk_pkg::FILL_MAX))
        else $error("fill above 100 percent");

endmodule

// File: tb/tb.sv
module tb;

    localparam int DIST_SCALE    = 1 << fflk_pkg::DIST_FRAC_BITS_DEF;
    localparam int ITEMS_PER_SEG = 125;
    localparam int NUM_SEGS      = 6;
    localparam int HOLD_CYCLES   = 600;
    localparam int DRAIN_CYCLES  = 200;
    localparam logic [2:0] ADDR_THR  = {fflk_pkg::REG_THRESHOLD, 2'b00};
    localparam logic [2:0] ADDR_MAXD = {fflk_pkg::REG_MAX_DIST, 2'b00};

    // Expected result of one item
    typedef struct packed {
        logic [2:0][14:0] fill;     // plastic, paper, metal (index 0 first)
        logic             locked;
        logic             entered;
        logic             released;
    } fill_result_t;

    // Directed stimulus row: config, six distances, optional hand-worked fills
    typedef struct packed {
        logic [6:0]       thr;
        logic [9:0]       maxd;
        logic [5:0][11:0] dists;    // index 0 = plastic_front ... 5 = metal_back
        logic             typed;
        logic [2:0][14:0] fill;     // index 0 = plastic
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state and config shadow
    logic         lock_state;
    logic [6:0]   cfg_thr;
    logic [9:0]   cfg_maxd;
    fill_result_t fill_expect_q [$];

    int  err_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;

    string FILL_NAME [3] = '{"plastic_fill", "paper_fill", "metal_fill"};
    string FLAG_NAME [3] = '{"locked", "lock_entered", "lock_released"};

    // Distances listed metal_back first down to plastic_front; fills metal first
    dir_row_t dir_rows [22] = '{
        '{7'd75, 10'd688, {6{12'h000}}, 1'b1, {3{15'd25600}}},
        '{7'd75, 10'd688, {6{12'h7FF}}, 1'b1, {3{15'd0}}},
        '{7'd75, 10'd688, {6{12'h800}}, 1'b1, {3{15'd25600}}},
        '{7'd75, 10'd688, {6{12'hFFF}}, 1'b1, {3{15'd25600}}},
        '{7'd75, 10'd688, {12'd368, 12'd368, 12'd0, 12'd688, 12'd688, 12'd0}, 1'b1,
          {15'd12800, 15'd25600, 15'd25600}},
        '{7'd75, 10'd688, {12'd688, 12'd688, 12'd368, 12'd688, 12'd688, 12'd368}, 1'b1,
          {15'd0, 15'd12800, 15'd12800}},
        '{7'd75, 10'd688, {12'd608, 12'd560, 12'd400, 12'd160, 12'd240, 12'd128}, 1'b0,
          {3{15'd0}}},
        '{7'd75, 10'd688, {12'd607, 12'd559, 12'd401, 12'd161, 12'd239, 12'd129}, 1'b0,
          {3{15'd0}}},
        '{7'd75, 10'd688, {12'd609, 12'd561, 12'd399, 12'd159, 12'd241, 12'd127}, 1'b0,
          {3{15'd0}}},
        '{7'd75, 10'd0, {6{12'h7FF}}, 1'b1, {3{15'd25600}}},
        '{7'd75, 10'd0, {12'h800, 12'h001, 12'h3FF, 12'hABC, 12'h555, 12'h7FE}, 1'b1,
          {3{15'd25600}}},
        '{7'd75, 10'd1023, {6{12'h7FF}}, 1'b1, {3{15'd0}}},
        '{7'd75, 10'd1023, {12'h400, 12'h3FF, 12'h401, 12'h3FE, 12'h7FF, 12'h260}, 1'b1,
          {3{15'd0}}},
        '{7'd0, 10'd1023, {6{12'h7FF}}, 1'b1, {3{15'd0}}},
        '{7'd0, 10'd1023, {12'd300, 12'd50, 12'd700, 12'd200, 12'd450, 12'd30}, 1'b0,
          {3{15'd0}}},
        '{7'd127, 10'd688, {6{12'h000}}, 1'b1, {3{15'd25600}}},
        '{7'd127, 10'd688, {6{12'h7FF}}, 1'b1, {3{15'd0}}},
        '{7'd100, 10'd688, {6{12'h000}}, 1'b1, {3{15'd25600}}},
        '{7'd100, 10'd688, {12'd688, 12'd688, 12'd688, 12'd688, 12'd0, 12'd0}, 1'b1,
          {15'd0, 15'd0, 15'd25600}},
        '{7'd100, 10'd688, {6{12'd368}}, 1'b1, {3{15'd12800}}},
        '{7'd75, 10'd688, {12'd500, 12'd250, 12'd100, 12'd450, 12'd300, 12'd200}, 1'b0,
          {3{15'd0}}},
        '{7'd75, 10'd688, {12'hFFF, 12'h555, 12'hAAA, 12'h2AA, 12'h7FE, 12'h801}, 1'b0,
          {3{15'd0}}}
    };

    fuzzy_fill_level_lock_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Membership degrees, Q1.12, truncated
    function automatic int unsigned near_deg(input int unsigned x);
        if (x <= 8 * DIST_SCALE)
            return 4096;
        if (x >= 15 * DIST_SCALE)
            return 0;
        return (15 * DIST_SCALE - x) * 4096 / (7 * DIST_SCALE);
    endfunction

    function automatic int unsigned medium_deg(input int unsigned x);
        if (x <= 10 * DIST_SCALE || x >= 35 * DIST_SCALE)
            return 0;
        if (x <= 23 * DIST_SCALE)
            return (x - 10 * DIST_SCALE) * 4096 / (13 * DIST_SCALE);
        return (35 * DIST_SCALE - x) * 4096 / (12 * DIST_SCALE);
    endfunction

    function automatic int unsigned far_deg(input int unsigned x);
        if (x <= 25 * DIST_SCALE)
            return 0;
        if (x >= 38 * DIST_SCALE)
            return 4096;
        return (x - 25 * DIST_SCALE) * 4096 / (13 * DIST_SCALE);
    endfunction

    // One bin: clamp, fuzzify, nine min-rules, weighted average in 1/256 percent
    function automatic logic [14:0] predict_fill(input logic [11:0] front_raw,
                                                 input logic [11:0] back_raw);
        int unsigned     f, b, c;
        int unsigned     fdeg [3];
        int unsigned     bdeg [3];
        longint unsigned num, den, w;
        f = front_raw[11] ? 0 : ((front_raw > cfg_maxd) ? cfg_maxd : front_raw);
        b = back_raw[11] ? 0 : ((back_raw > cfg_maxd) ? cfg_maxd : back_raw);
        // index 0 far, 1 medium, 2 near
        fdeg[0] = far_deg(f);
        fdeg[1] = medium_deg(f);
        fdeg[2] = near_deg(f);
        bdeg[0] = far_deg(b);
        bdeg[1] = medium_deg(b);
        bdeg[2] = near_deg(b);
        num = 0;
        den = 0;
        for (int r = 0; r < 9; r++)
        begin
            w = (fdeg[r / 3] < bdeg[r % 3]) ? fdeg[r / 3] : bdeg[r % 3];
            c = (r == 0) ? 0 : ((r == 1 || r == 3 || r == 4) ? 50 : 100);
            num += w * c;
            den += w;
        end
        if (den == 0)
            return '0;
        return 15'(num * 256 / den);
    endfunction

    // Lock flag update and edge pulses
    function automatic fill_result_t settle_lock(input logic [2:0][14:0] fills);
        fill_result_t r;
        logic         now;
        now = 1'b0;
        for (int i = 0; i < 3; i++)
            if (int'(fills[i]) >= int'(cfg_thr) * 256)
                now = 1'b1;
        r.fill     = fills;
        r.locked   = now;
        r.entered  = now && !lock_state;
        r.released = !now && lock_state;
        lock_state = now;
        return r;
    endfunction

    // Random distance: raw noise, in-range values, knee points, clamp edges
    function automatic logic [11:0] rand_dist();
        int unsigned sel;
        int unsigned knee [7] = '{128, 160, 240, 368, 400, 560, 608};
        sel = $urandom_range(9);
        if (sel < 2)
            return 12'($urandom);
        if (sel < 8)
            return 12'($urandom_range(int'(cfg_maxd) + 16));
        if (sel == 8)
            return 12'(knee[$urandom_range(6)] + $urandom_range(4) - 2);
        case ($urandom_range(5))
            0:       return 12'h000;
            1:       return 12'h7FF;
            2:       return 12'hFFF;
            3:       return 12'h800;
            4:       return 12'(cfg_maxd);
            default: return 12'(cfg_maxd + 1);
        endcase
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want,
                                  input string name);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, prdata);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Drain all results, then write both registers (junk in the upper bits) and read back
    task automatic reconfigure(input logic [6:0] thr, input logic [9:0] maxd);
        s_tvalid <= 1'b0;
        while (fill_expect_q.size() != 0)
            @(posedge clk);
        apb_write(ADDR_THR, {25'($urandom), thr});
        cfg_thr = thr;
        apb_read_check(ADDR_THR, {25'b0, thr}, "lock_threshold");
        apb_write(ADDR_MAXD, {22'($urandom), maxd});
        cfg_maxd = maxd;
        apb_read_check(ADDR_MAXD, {22'b0, maxd}, "max_distance");
    endtask

    // Offer one item; on accept, queue its expected result
    task automatic offer_distances(input logic [5:0][11:0] dists, input logic typed,
                                   input logic [2:0][14:0] typed_fill);
        logic [2:0][14:0] fills;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 72'({$urandom, $urandom, $urandom});
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= dists;
        do
            @(posedge clk);
        while (!s_tready);
        for (int i = 0; i < 3; i++)
            fills[i] = typed ? typed_fill[i] : predict_fill(dists[2 * i], dists[2 * i + 1]);
        fill_expect_q.push_back(settle_lock(fills));
    endtask

    // Result side: check, then pick next ready (long hold-off on request)
    always @(posedge clk)
    begin : result_side
        fill_result_t want;
        logic [2:0]   want_flags;
        if (m_tvalid && m_tready)
        begin
            if (fill_expect_q.size() == 0)
            begin
                $error("result item with nothing expected");
                err_count++;
            end
            else
            begin
                want = fill_expect_q.pop_front();
                want_flags = {want.released, want.entered, want.locked};
                for (int i = 0; i < 3; i++)
                begin
                    if (m_tdata[15 * i +: 15] !== want.fill[i])
                    begin
                        $error("%s: expected %0d, got %0d", FILL_NAME[i], want.fill[i],
                               m_tdata[15 * i +: 15]);
                        err_count++;
                    end
                    if (m_tuser[i] !== want_flags[i])
                    begin
                        $error("%s: expected %0d, got %0d", FLAG_NAME[i], want_flags[i],
                               m_tuser[i]);
                        err_count++;
                    end
                end
            end
        end
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Main sequence
    initial
    begin
        logic [5:0][11:0] dists;
        logic [6:0]       thr;
        logic [9:0]       maxd;
        lock_state = 1'b0;
        cfg_thr    = fflk_pkg::THR_RESET;
        cfg_maxd   = fflk_pkg::MAXD_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_read_check(ADDR_THR, {25'b0, fflk_pkg::THR_RESET}, "lock_threshold");
        apb_read_check(ADDR_MAXD, {22'b0, fflk_pkg::MAXD_RESET}, "max_distance");

        // Directed rows
        send_idle_pct = 28;
        recv_idle_pct = 76;
        for (int n = 0; n < $size(dir_rows); n++)
        begin
            if (dir_rows[n].thr != cfg_thr || dir_rows[n].maxd != cfg_maxd)
                reconfigure(dir_rows[n].thr, dir_rows[n].maxd);
            offer_distances(dir_rows[n].dists, dir_rows[n].typed, dir_rows[n].fill);
        end

        // Random segments, each under its own setting
        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            case (seg)
                0: begin thr = 7'd60;  maxd = 10'd1023; end
                1: begin thr = 7'd0;   maxd = 10'd300;  end
                2: begin thr = 7'd127; maxd = 10'd500;  end
                3: begin thr = 7'd100; maxd = 10'd688;  end
                default:
                begin
                    thr  = 7'($urandom_range(110));
                    maxd = 10'($urandom_range(1023));
                end
            endcase
            send_idle_pct = (seg < 2) ? 28 : ((seg < 4) ? 76 : 0);
            recv_idle_pct = (seg < 2) ? 76 : ((seg < 4) ? 28 : 0);
            reconfigure(thr, maxd);
            // receiver stalls while the sender keeps pushing
            if (seg == 4)
                hold_req = 1'b1;
            repeat (ITEMS_PER_SEG)
            begin
                for (int i = 0; i < 6; i++)
                    dists[i] = rand_dist();
                offer_distances(dists, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (fill_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
